[rtl/ovlt_pkg.sv]
// shared types and codes for the ordered value list table
package ovlt_pkg;

   localparam int FUNC_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;

   typedef logic [FUNC_W-1:0]          func_type;
   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic [STATUS_W-1:0]        status_type;

   localparam func_type FUNC_APPEND = 2'd0;
   localparam func_type FUNC_SEARCH = 2'd1;
   localparam func_type FUNC_DELETE = 2'd2;
   localparam func_type FUNC_LIST   = 2'd3;

   localparam status_type ST_DONE      = 3'd0;
   localparam status_type ST_FOUND     = 3'd1;
   localparam status_type ST_NOT_FOUND = 3'd2;
   localparam status_type ST_EMPTY     = 3'd3;
   localparam status_type ST_FULL      = 3'd4;

endpackage

[rtl/ovlt_store.sv]
// entry storage: one write port, one registered read port
module ovlt_store import ovlt_pkg::*; #(
   parameter int CAPACITY = 16,
   parameter int IDX_W    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  value_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output value_type        rd_data
);

   value_type mem [CAPACITY];
   value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ovlt_ctrl.sv]
// command sequencer: scan, compare, gap closing and result register
module ovlt_ctrl import ovlt_pkg::*; #(
   parameter int CAPACITY = 16,
   parameter int IDX_W    = 4,
   parameter int CNT_W    = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  func_type         req_func,
   input  value_type        req_value,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output status_type       rsp_status,
   output value_type        rsp_entry_value,
   output logic             rsp_last_of_run,
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_addr,
   output value_type        wr_data,
   output logic [IDX_W-1:0] rd_addr,
   input  value_type        rd_data
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_READ     = 3'd1;
   localparam logic [2:0] S_CHECK    = 3'd2;
   localparam logic [2:0] S_SHIFT_RD = 3'd3;
   localparam logic [2:0] S_SHIFT_WR = 3'd4;
   localparam logic [2:0] S_EMIT     = 3'd5;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   func_type         func_ff, func_in;
   value_type        key_ff, key_in;
   status_type       pend_status_ff, pend_status_in;
   value_type        pend_value_ff, pend_value_in;
   logic             pend_last_ff, pend_last_in;
   logic             pend_cont_ff, pend_cont_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   value_type        rsp_value_ff, rsp_value_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0] idx_nx;
   logic             is_last;
   logic             hit;

   assign idx_nx  = CNT_W'(idx_ff) + CNT_W'(1);
   assign is_last = (idx_nx == count_ff);
   assign hit     = (rd_data == key_ff);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      func_in        = func_ff;
      key_in         = key_ff;
      pend_status_in = pend_status_ff;
      pend_value_in  = pend_value_ff;
      pend_last_in   = pend_last_ff;
      pend_cont_in   = pend_cont_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_data        = rd_data;
      rd_addr        = idx_ff;
      req_stall      = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in        = req_func;
               key_in         = req_value;
               idx_in         = '0;
               pend_value_in  = '0;
               pend_last_in   = 1'b1;
               pend_cont_in   = 1'b0;
               pend_status_in = ST_DONE;
               if (req_func == FUNC_APPEND) begin
                  if (count_ff == CAP_CNT) begin
                     pend_status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IDX_W-1:0];
                     wr_data  = req_value;
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = S_EMIT;
               end else if (count_ff == '0) begin
                  pend_status_in = ST_EMPTY;
                  state_in       = S_EMIT;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            case (func_ff)
               FUNC_SEARCH, FUNC_DELETE: begin
                  if (hit && func_ff == FUNC_SEARCH) begin
                     pend_status_in = ST_FOUND;
                     state_in       = S_EMIT;
                  end else if (hit) begin
                     if (is_last) begin
                        count_in       = count_ff - CNT_W'(1);
                        pend_status_in = ST_DONE;
                        state_in       = S_EMIT;
                     end else begin
                        state_in = S_SHIFT_RD;
                     end
                  end else if (is_last) begin
                     pend_status_in = ST_NOT_FOUND;
                     state_in       = S_EMIT;
                  end else begin
                     idx_in   = idx_nx[IDX_W-1:0];
                     state_in = S_READ;
                  end
               end
               default: begin
                  pend_status_in = ST_DONE;
                  pend_value_in  = rd_data;
                  pend_last_in   = is_last;
                  pend_cont_in   = ~is_last;
                  state_in       = S_EMIT;
               end
            endcase
         end
         S_SHIFT_RD: begin
            rd_addr  = idx_nx[IDX_W-1:0];
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            idx_in  = idx_nx[IDX_W-1:0];
            if (idx_nx + CNT_W'(1) == count_ff) begin
               count_in       = count_ff - CNT_W'(1);
               pend_status_in = ST_DONE;
               state_in       = S_EMIT;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_value_in  = pend_value_ff;
               rsp_last_in   = pend_last_ff;
               if (pend_cont_ff) begin
                  idx_in   = idx_nx[IDX_W-1:0];
                  state_in = S_READ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      func_ff        <= func_in;
      key_ff         <= key_in;
      pend_status_ff <= pend_status_in;
      pend_value_ff  <= pend_value_in;
      pend_last_ff   <= pend_last_in;
      pend_cont_ff   <= pend_cont_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

[rtl/ordered_value_list_table_top.sv]
// Ordered list of up to CAPACITY signed 32-bit values kept in insertion order.
// Append (func 0) stores at the tail or answers full; search (1) reports found
// or not found; delete (2) removes the first equal value and moves the later
// entries down one place; list (3) returns every entry head to tail, with
// last_of_run on the tail beat. Search, delete and list on an empty list give
// one beat with status empty. Every command gives one beat except list.
// Entries sit in a single-port-write, registered-read memory and one sequencer
// with one comparator walks it: each visited entry is read, then compared.
// Delete closes the gap by reading and then writing each later entry; list
// reads each entry, captures it and emits it before it reads the next. The
// request side stalls from acceptance until the last result beat of that
// command has been loaded into the output register.
module ordered_value_list_table_top import ovlt_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  func_type   req_func,
   input  value_type  req_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output status_type rsp_status,
   output value_type  rsp_entry_value,
   output logic       rsp_last_of_run
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   value_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   value_type        rd_data;

   ovlt_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_last_of_run (rsp_last_of_run),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   ovlt_store #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

[test/ovlt_tb_pkg.sv]
// scoreboard class that predicts and checks result beats of the ordered value list table
`timescale 1ns / 1ps
package ovlt_tb_pkg;
   import ovlt_pkg::*;

   typedef struct {
      status_type status;
      value_type  entry_value;
      logic       last_of_run;
   } beat_type;

   class list_scoreboard;
      int        capacity;
      int        errors;
      value_type shadow_entries[$];
      beat_type  expected_beats[$];

      function new(int capacity_i);
         capacity = capacity_i;
         errors = 0;
      endfunction

      task report(string msg);
         $display("tb: mismatch: %s", msg);
         errors++;
      endtask

      function void push_beat(status_type s, value_type v, logic last);
         beat_type b;
         b.status = s;
         b.entry_value = v;
         b.last_of_run = last;
         expected_beats.push_back(b);
      endfunction

      function int count();
         return shadow_entries.size();
      endfunction

      function int outstanding();
         return expected_beats.size();
      endfunction

      function value_type pick_entry();
         return shadow_entries[$urandom_range(shadow_entries.size() - 1)];
      endfunction

      // apply one accepted command to the shadow list and queue its beats
      function void apply_command(func_type f, value_type v);
         int pos;
         int n;
         pos = -1;
         n = shadow_entries.size();
         for (int i = 0; i < n; i++)
            if (pos < 0 && shadow_entries[i] == v) pos = i;
         if (f == FUNC_APPEND) begin
            if (n >= capacity) begin
               push_beat(ST_FULL, '0, 1'b1);
            end else begin
               shadow_entries.push_back(v);
               push_beat(ST_DONE, '0, 1'b1);
            end
         end else if (n == 0) begin
            push_beat(ST_EMPTY, '0, 1'b1);
         end else if (f == FUNC_SEARCH) begin
            push_beat((pos >= 0) ? ST_FOUND : ST_NOT_FOUND, '0, 1'b1);
         end else if (f == FUNC_DELETE) begin
            if (pos < 0) begin
               push_beat(ST_NOT_FOUND, '0, 1'b1);
            end else begin
               shadow_entries.delete(pos);
               push_beat(ST_DONE, '0, 1'b1);
            end
         end else begin
            for (int i = 0; i < n; i++)
               push_beat(ST_DONE, shadow_entries[i], (i == n - 1));
         end
      endfunction

      task check_beat(status_type s, value_type v, logic last);
         beat_type b;
         if (expected_beats.size() == 0) begin
            report($sformatf("unexpected beat status %0d value %0d", s, v));
         end else begin
            b = expected_beats.pop_front();
            if (s !== b.status)
               report($sformatf("status %0d, expected %0d", s, b.status));
            if (v !== b.entry_value)
               report($sformatf("entry_value %0d, expected %0d", v, b.entry_value));
            if (last !== b.last_of_run)
               report($sformatf("last_of_run %0b, expected %0b", last, b.last_of_run));
         end
      endtask
   endclass

endpackage

[test/tb.sv]
// top-level testbench for the ordered value list table
`timescale 1ns / 1ps
module tb;
   import ovlt_pkg::*;
   import ovlt_tb_pkg::*;

   localparam int CAPACITY = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEMS_PER_PHASE = 30;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid;
   logic       req_stall;
   func_type   req_func;
   value_type  req_value;
   logic       rsp_valid;
   logic       rsp_stall;
   status_type rsp_status;
   value_type  rsp_entry_value;
   logic       rsp_last_of_run;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycle_count = 0;

   list_scoreboard sb = new(CAPACITY);

   ordered_value_list_table_top #(.CAPACITY(CAPACITY)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_entry_value(rsp_entry_value),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_beat(rsp_status, rsp_entry_value, rsp_last_of_run);
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_command(func_type f, value_type v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 40 : 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_func = f;
      req_value = v;
      do @(posedge clock); while (req_stall);
      sb.apply_command(f, v);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   function automatic func_type pick_func();
      int n;
      int roll;
      int app_pct;
      n = sb.count();
      roll = $urandom_range(99);
      app_pct = (n < 4) ? 55 : (n > 12) ? 25 : 40;
      if (roll < app_pct) return FUNC_APPEND;
      if (roll < app_pct + 20) return FUNC_SEARCH;
      if (roll < app_pct + 45) return FUNC_DELETE;
      return FUNC_LIST;
   endfunction

   function automatic value_type pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 35 && sb.count() > 0) return sb.pick_entry();
      if (sel < 60) return value_type'($urandom_range(7)) - value_type'(3);
      if (sel < 70) begin
         case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            default: return '1;
         endcase
      end
      return value_type'($urandom());
   endfunction

   initial begin
      req_valid = 1'b0;
      req_func = FUNC_APPEND;
      req_value = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list, then deleting the only entry
      send_command(FUNC_LIST, '0);
      send_command(FUNC_SEARCH, 32'sd5);
      send_command(FUNC_DELETE, 32'sd5);
      send_command(FUNC_APPEND, 32'sh8000_0000);
      send_command(FUNC_DELETE, 32'sh8000_0000);
      send_command(FUNC_LIST, '0);
      send_command(FUNC_APPEND, 32'sh8000_0000);
      send_command(FUNC_APPEND, 32'sh7fff_ffff);
      send_command(FUNC_APPEND, '0);
      send_command(FUNC_APPEND, '1);
      send_command(FUNC_APPEND, 32'sh7fff_ffff);
      send_command(FUNC_SEARCH, 32'sh7fff_ffff);
      send_command(FUNC_SEARCH, 32'sh7fff_fffe);
      send_command(FUNC_DELETE, 32'sh7fff_ffff);
      send_command(FUNC_DELETE, 32'sd12345);
      send_command(FUNC_LIST, '0);
      // fill to capacity, then overflow
      while (sb.count() < CAPACITY) send_command(FUNC_APPEND, value_type'($urandom()));
      send_command(FUNC_APPEND, 32'sd1);
      send_command(FUNC_LIST, '0);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            send_command(pick_func(), pick_value());
            if (k == ITEMS_PER_PHASE / 2) drain_results();
         end
         drain_results();
      end

      recv_stall_pct = 0;
      repeat (60) @(negedge clock);
      if (sb.outstanding() != 0)
         sb.report($sformatf("%0d beats never arrived", sb.outstanding()));
      if (sb.errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
